>>> hdl/csa_pkg.sv
// shared constants for the contiguous spectrum slot allocator
package csa_pkg;

  localparam int DEF_MAX_SLOTS       = 64;
  localparam int DEF_MAX_WAVELENGTHS = 4;
  localparam int DEF_LINKS           = 32;
  localparam int DEF_ID_WIDTH        = 16;

  // field widths
  localparam int KIND_W  = 1;
  localparam int MASK_W  = 32;
  localparam int REQ_W   = 7;
  localparam int HOLD_W  = 16;
  localparam int RID_W   = 16;
  localparam int WL_W    = 2;
  localparam int START_W = 6;
  localparam int FRESH_W = 7;
  localparam int NODES_W = 6;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 23;
  localparam int SLOTS_CFG_W = 7;
  localparam int WLS_CFG_W   = 3;

  localparam logic [CFG_IW-1:0] REG_SLOTS     = 2'd0;
  localparam logic [CFG_IW-1:0] REG_WLS       = 2'd1;
  localparam logic [CFG_IW-1:0] REG_POLICY    = 2'd2;
  localparam logic [CFG_IW-1:0] REG_THRESHOLD = 2'd3;

  localparam logic [SLOTS_CFG_W-1:0] SLOTS_RST     = 7'd64;
  localparam logic [WLS_CFG_W-1:0]   WLS_RST       = 3'd1;
  localparam logic [CFG_DW-1:0]      THRESHOLD_RST = 23'd512;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

endpackage

>>> hdl/csa_ram.sv
// generic single write port, single read port ram with registered read
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> hdl/contiguous_spectrum_slot_allocator_core.sv
// contiguous spectrum slot allocator: first fit slot runs over a path of links, from either end
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  input    | in_kind in_link_mask in_slots_required  | beat on start & !busy
//           | in_hold_time in_request_id              |
//  result   | out_granted out_wavelength ...          | one cycle beat on out_valid
//  config   | cfg_we cfg_index cfg_data               | write on cfg_we
//
// one item at a time; busy is high from acceptance until the result beat
// allocate: per wavelength tried, a scan that reads the row of every link and a
//   walk of up to n slots for a free run; on success a read of every link's row,
//   a rewrite of the rows on the path and a walk of n slots for the fresh run
// release: a read and rewrite sweep over every row, clearing the slots the id owns
// reset is synchronous; row valid bits make every row read as free after reset
// the receiver cannot stall: out_valid is high for exactly one cycle
module contiguous_spectrum_slot_allocator_core #(
  parameter int MAX_SLOTS       = csa_pkg::DEF_MAX_SLOTS,
  parameter int MAX_WAVELENGTHS = csa_pkg::DEF_MAX_WAVELENGTHS,
  parameter int LINKS           = csa_pkg::DEF_LINKS,
  parameter int ID_WIDTH        = csa_pkg::DEF_ID_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [csa_pkg::KIND_W-1:0]    in_kind,
  input  logic [csa_pkg::MASK_W-1:0]    in_link_mask,
  input  logic [csa_pkg::REQ_W-1:0]     in_slots_required,
  input  logic [csa_pkg::HOLD_W-1:0]    in_hold_time,
  input  logic [csa_pkg::RID_W-1:0]     in_request_id,
  output logic                          out_valid,
  output logic                          out_granted,
  output logic [csa_pkg::WL_W-1:0]      out_wavelength,
  output logic [csa_pkg::START_W-1:0]   out_start_slot,
  output logic [csa_pkg::FRESH_W-1:0]   out_max_fresh_run,
  output logic [csa_pkg::NODES_W-1:0]   out_path_nodes,
  input  logic                          cfg_we,
  input  logic [csa_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [csa_pkg::CFG_DW-1:0]    cfg_data
);
  import csa_pkg::*;

  localparam int DEPTH = MAX_WAVELENGTHS * LINKS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = MAX_SLOTS * (ID_WIDTH + 1);
  localparam int SW    = $clog2(MAX_SLOTS);
  localparam int CW    = ($clog2(MAX_SLOTS + 1) > REQ_W) ? $clog2(MAX_SLOTS + 1) : REQ_W;
  localparam int WLW   = (MAX_WAVELENGTHS > 1) ? $clog2(MAX_WAVELENGTHS) : 1;
  localparam int WCW   = ($clog2(MAX_WAVELENGTHS + 1) > WLS_CFG_W) ?
                         $clog2(MAX_WAVELENGTHS + 1) : WLS_CFG_W;
  localparam int LW    = $clog2(LINKS);
  localparam int LCW   = $clog2(LINKS + 1);
  localparam int NW    = $clog2(LINKS + 2);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_SRCH = 4'd2;
  localparam logic [3:0] S_WRRD = 4'd3;
  localparam logic [3:0] S_WRWR = 4'd4;
  localparam logic [3:0] S_FRSH = 4'd5;
  localparam logic [3:0] S_RLRD = 4'd6;
  localparam logic [3:0] S_RLWR = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // configuration registers
  logic [SLOTS_CFG_W-1:0] slots_cfg_r;
  logic [WLS_CFG_W-1:0]   wls_cfg_r;
  logic                   policy_r;
  logic [CFG_DW-1:0]      thr_r;

  // sequencer and item registers
  logic [3:0]          state_r;
  logic                busy_r;
  logic                rel_r;
  logic [LINKS-1:0]    mask_r;
  logic [REQ_W-1:0]    req_r;
  logic [ID_WIDTH-1:0] id_r;
  logic                high_r;
  logic [CW-1:0]       n_r;
  logic [WCW-1:0]      nwl_r;
  logic [WLW-1:0]      wl_r;
  logic [LCW-1:0]      lnk_r;
  logic                rd_pend_r;
  logic [LW-1:0]       rd_lnk_r;
  logic [MAX_SLOTS-1:0] busy_acc_r;
  logic [MAX_SLOTS-1:0] used_acc_r;
  logic [SW-1:0]       s_r;
  logic [CW-1:0]       run_r;
  logic [SW-1:0]       start_r;
  logic [CW-1:0]       cur_r;
  logic [CW-1:0]       best_r;
  logic [NW-1:0]       nodes_r;
  logic [AW-1:0]       row_r;
  logic [DEPTH-1:0]    vld_r;
  logic                rvld_r;

  // result registers
  logic                out_valid_r;
  logic                out_granted_r;
  logic [WL_W-1:0]     out_wl_r;
  logic [START_W-1:0]  out_start_r;
  logic [FRESH_W-1:0]  out_fresh_r;
  logic [NODES_W-1:0]  out_nodes_r;

  // combinational
  logic                accept;
  logic [ID_WIDTH-1:0] id_in;
  logic [LINKS-1:0]    mask_in;
  logic [CFG_DW-1:0]   prod;
  logic [CW-1:0]       slots_ext;
  logic [CW-1:0]       n_eff;
  logic [WCW-1:0]      wls_ext;
  logic [WCW-1:0]      nwl_eff;
  logic [LW-1:0]       lnk_idx;
  logic [AW-1:0]       raddr;
  logic [RW-1:0]       ram_rdata;
  logic [RW-1:0]       rdata_m;
  logic [RW-1:0]       wdata;
  logic                we;
  logic [MAX_SLOTS-1:0] own_nz;
  logic [MAX_SLOTS-1:0] used_row;
  logic [MAX_SLOTS-1:0] runm;
  logic [RW-1:0]       alloc_row;
  logic [RW-1:0]       rel_row;
  logic                free_s;
  logic                fresh_s;
  logic [CW-1:0]       run_nxt;
  logic [CW-1:0]       cur_nxt;
  logic [CW-1:0]       best_nxt;
  logic                last_s;
  logic                bad_req;

  assign accept = start && !busy_r;

  always_comb begin
    for (int i = 0; i < ID_WIDTH; i++) begin
      id_in[i] = (i < RID_W) ? in_request_id[i] : 1'b0;
    end
    for (int i = 0; i < LINKS; i++) begin
      mask_in[i] = (i < MASK_W) ? in_link_mask[i] : 1'b0;
    end
  end

  // hold time (Q8.8) times integer slot count, against the Q.8 limit
  assign prod = in_hold_time * in_slots_required;

  // register values out of range are clamped
  assign slots_ext = CW'(slots_cfg_r);
  assign n_eff = (slots_ext == '0) ? CW'(1) :
                 (slots_ext > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : slots_ext;
  assign wls_ext = WCW'(wls_cfg_r);
  assign nwl_eff = (wls_ext == '0) ? WCW'(1) :
                   (wls_ext > WCW'(MAX_WAVELENGTHS)) ? WCW'(MAX_WAVELENGTHS) : wls_ext;

  assign lnk_idx = (lnk_r < LCW'(LINKS)) ? lnk_r[LW-1:0] : '0;

  always_comb begin
    unique case (state_r)
      S_RLRD, S_RLWR: raddr = row_r;
      default:        raddr = AW'(int'(wl_r) * LINKS + int'(lnk_idx));
    endcase
  end

  csa_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (raddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // a row never written reads as all free and never used
  assign rdata_m = rvld_r ? ram_rdata : '0;

  // per slot views of the row just read, and the row rewrites
  always_comb begin
    alloc_row = rdata_m;
    rel_row   = rdata_m;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      own_nz[i]   = |rdata_m[i*ID_WIDTH +: ID_WIDTH];
      used_row[i] = rdata_m[MAX_SLOTS*ID_WIDTH + i];
      runm[i]     = ((CW+1)'(i) >= (CW+1)'(start_r)) &&
                    ((CW+1)'(i) < ((CW+1)'(start_r) + (CW+1)'(req_r)));
      if (runm[i]) begin
        alloc_row[i*ID_WIDTH +: ID_WIDTH] = id_r;
        alloc_row[MAX_SLOTS*ID_WIDTH + i] = 1'b1;
      end
      if (rdata_m[i*ID_WIDTH +: ID_WIDTH] == id_r) begin
        rel_row[i*ID_WIDTH +: ID_WIDTH] = '0;
      end
    end
  end

  assign we    = ((state_r == S_WRWR) && mask_r[lnk_idx]) || (state_r == S_RLWR);
  assign wdata = (state_r == S_RLWR) ? rel_row : alloc_row;

  // slot walk datapath, shared by run search and fresh run count
  assign free_s   = !busy_acc_r[s_r];
  assign run_nxt  = free_s ? run_r + CW'(1) : '0;
  assign fresh_s  = !used_acc_r[s_r] && !((|mask_r) && runm[s_r]);
  assign cur_nxt  = fresh_s ? cur_r + CW'(1) : '0;
  assign best_nxt = (cur_nxt > best_r) ? cur_nxt : best_r;
  assign last_s   = high_r ? (s_r == '0) : (s_r == SW'(n_r - CW'(1)));
  assign bad_req  = (id_r == '0) || (req_r == '0) || (CW'(req_r) > n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_cfg_r <= SLOTS_RST;
      wls_cfg_r   <= WLS_RST;
      policy_r    <= 1'b0;
      thr_r       <= THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOTS:     slots_cfg_r <= cfg_data[SLOTS_CFG_W-1:0];
        REG_WLS:       wls_cfg_r   <= cfg_data[WLS_CFG_W-1:0];
        REG_POLICY:    policy_r    <= cfg_data[0];
        REG_THRESHOLD: thr_r       <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rvld_r <= vld_r[raddr];
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (we) begin
        vld_r[raddr] <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            busy_r        <= 1'b1;
            rel_r         <= (in_kind == KIND_RELEASE);
            mask_r        <= mask_in;
            req_r         <= in_slots_required;
            id_r          <= id_in;
            high_r        <= policy_r && (prod > thr_r);
            n_r           <= n_eff;
            nwl_r         <= nwl_eff;
            wl_r          <= '0;
            lnk_r         <= '0;
            row_r         <= '0;
            rd_pend_r     <= 1'b0;
            busy_acc_r    <= '0;
            used_acc_r    <= '0;
            nodes_r       <= '0;
            out_granted_r <= 1'b0;
            out_wl_r      <= '0;
            out_start_r   <= '0;
            out_fresh_r   <= '0;
            if (in_kind == KIND_RELEASE) begin
              state_r <= (id_in == '0) ? S_DONE : S_RLRD;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // one row read issued per cycle, its data folded in on the cycle after
          if (lnk_r != LCW'(LINKS)) begin
            lnk_r     <= lnk_r + LCW'(1);
            rd_pend_r <= 1'b1;
            rd_lnk_r  <= lnk_idx;
          end else begin
            rd_pend_r <= 1'b0;
          end
          if (rd_pend_r && mask_r[rd_lnk_r]) begin
            busy_acc_r <= busy_acc_r | own_nz;
            used_acc_r <= used_acc_r | used_row;
            if (wl_r == '0) begin
              nodes_r <= nodes_r + NW'(1);
            end
          end
          if (lnk_r == LCW'(LINKS)) begin
            if (bad_req) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_SRCH;
              s_r     <= high_r ? SW'(n_r - CW'(1)) : '0;
              run_r   <= '0;
            end
          end
        end
        S_SRCH: begin
          run_r <= run_nxt;
          if (run_nxt == CW'(req_r)) begin
            start_r <= high_r ? s_r : SW'(CW'(s_r) + CW'(1) - CW'(req_r));
            lnk_r   <= '0;
            state_r <= S_WRRD;
          end else if (last_s) begin
            // no run on this wavelength: try the next one, or finish if it was the last
            if (WCW'(wl_r) + WCW'(1) == nwl_r) begin
              state_r <= S_DONE;
            end else begin
              wl_r       <= wl_r + WLW'(1);
              lnk_r      <= '0;
              busy_acc_r <= '0;
              used_acc_r <= '0;
              state_r    <= S_SCAN;
            end
          end else begin
            s_r <= high_r ? s_r - SW'(1) : s_r + SW'(1);
          end
        end
        S_WRRD: begin
          state_r <= S_WRWR;
        end
        S_WRWR: begin
          if (lnk_r == LCW'(LINKS - 1)) begin
            s_r     <= '0;
            cur_r   <= '0;
            best_r  <= '0;
            state_r <= S_FRSH;
          end else begin
            lnk_r   <= lnk_r + LCW'(1);
            state_r <= S_WRRD;
          end
        end
        S_FRSH: begin
          cur_r  <= cur_nxt;
          best_r <= best_nxt;
          s_r    <= s_r + SW'(1);
          if (s_r == SW'(n_r - CW'(1))) begin
            out_granted_r <= 1'b1;
            out_wl_r      <= WL_W'(wl_r);
            out_start_r   <= START_W'(start_r);
            out_fresh_r   <= FRESH_W'(best_nxt);
            state_r       <= S_DONE;
          end
        end
        S_RLRD: begin
          state_r <= S_RLWR;
        end
        S_RLWR: begin
          if (row_r == AW'(DEPTH - 1)) begin
            out_granted_r <= 1'b1;
            state_r       <= S_DONE;
          end else begin
            row_r   <= row_r + AW'(1);
            state_r <= S_RLRD;
          end
        end
        S_DONE: begin
          out_nodes_r <= rel_r ? '0 : NODES_W'(nodes_r + NW'(1));
          out_valid_r <= 1'b1;
          busy_r      <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_wavelength    = out_wl_r;
  assign out_start_slot    = out_start_r;
  assign out_max_fresh_run = out_fresh_r;
  assign out_path_nodes    = out_nodes_r;
endmodule

>>> hdl/csa_checker.sv
// port level checks for the slot allocator, bound to the top level
module csa_port_props (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic                        out_granted,
  input logic [csa_pkg::WL_W-1:0]    out_wavelength,
  input logic [csa_pkg::START_W-1:0] out_start_slot,
  input logic [csa_pkg::FRESH_W-1:0] out_max_fresh_run
);
  import csa_pkg::*;

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // a result beat ends each busy period
  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result beat outside end of busy");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result beat");

  // a refused item carries no placement
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |->
      (out_wavelength == '0 && out_start_slot == '0 && out_max_fresh_run == '0))
    else $error("refused result carries placement");
endmodule

bind contiguous_spectrum_slot_allocator_core csa_port_props u_csa_props (.*);
